@@ src/ckt_pkg.sv @@
package ckt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int KEY_BYTES = 4;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_STORE  = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] card_key;
    logic [3:0]  slot_index;
  } ckt_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] key_out;
  } ckt_out_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
  } mem_req_t;

endpackage

@@ src/ckt_slot_mem.sv @@
module ckt_slot_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ckt_pkg::mem_req_t         mem_req_i,
  output logic [ckt_pkg::KEY_W-1:0] rd_data_o
);
  import ckt_pkg::*;

  logic [KEY_W-1:0]     mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q;
  logic [KEY_W-1:0]     rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= mem_req_i.wr_data;
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  // never-written slots read as empty (all ones)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (mem_req_i.wr_en) begin
        valid_q[mem_req_i.wr_addr] <= 1'b1;
      end
      if (mem_req_i.rd_en) begin
        rd_valid_q <= valid_q[mem_req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '1;

endmodule

@@ src/ckt_ctrl.sv @@
module ckt_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  ckt_pkg::ckt_in_t          in_data_i,
  output logic                      in_ready_o,
  output logic                      res_valid_o,
  output ckt_pkg::ckt_out_t         res_data_o,
  input  logic                      res_take_i,
  output ckt_pkg::mem_req_t         mem_req_o,
  input  logic [ckt_pkg::KEY_W-1:0] rd_data_i
);
  import ckt_pkg::*;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CNT_W-1:0]  addr_q, addr_d;
  logic [SLOT_W-1:0] tag_q, tag_d;
  logic              pend_q, pend_d;
  ckt_out_t          res_q, res_d;

  logic match, free, found, issue;

  assign match = (rd_data_i == key_q);
  assign free  = (rd_data_i[KEY_W-1 -: 8] == EMPTY_BYTE);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    addr_d    = addr_q;
    tag_d     = tag_q;
    pend_d    = pend_q;
    res_d     = res_q;
    mem_req_o = '0;
    found     = 1'b0;
    issue     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_data_i.req_type;
          key_d  = KEY_W'(in_data_i.card_key);
          res_d  = '0;
          pend_d = 1'b0;
          if (in_data_i.req_type == REQ_READ) begin
            if (32'(in_data_i.slot_index) < NUM_SLOTS) begin
              addr_d  = CNT_W'(in_data_i.slot_index);
              state_d = ST_SCAN;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            addr_d  = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // evaluate the slot read last cycle
        if (pend_q) begin
          unique case (req_q)
            REQ_LOOKUP: begin
              if (match) begin
                found     = 1'b1;
                res_d.hit = 1'b1;
              end
            end
            REQ_STORE: begin
              if (free) begin
                found             = 1'b1;
                res_d.hit         = 1'b1;
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = tag_q;
                mem_req_o.wr_data = key_q;
              end
            end
            REQ_REMOVE: begin
              if (match) begin
                found             = 1'b1;
                res_d.hit         = 1'b1;
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = tag_q;
                mem_req_o.wr_data = '1;
              end
            end
            REQ_READ: begin
              found         = 1'b1;
              res_d.hit     = !free;
              res_d.key_out = free ? '0 : 32'(rd_data_i);
            end
          endcase
        end

        // launch the next slot read unless the search just ended
        issue = !found && (addr_q < CNT_W'(NUM_SLOTS));
        if (issue) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = addr_q[SLOT_W-1:0];
          tag_d             = addr_q[SLOT_W-1:0];
          pend_d            = 1'b1;
          addr_d            = (req_q == REQ_READ) ? CNT_W'(NUM_SLOTS) : addr_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    key_q  <= key_d;
    addr_q <= addr_d;
    tag_q  <= tag_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_data_o  = res_q;

endmodule

@@ src/credential_key_table_unit.sv @@
// Card key table: NUM_SLOTS slots of KEY_BYTES-byte keys held in one
// single-port-read synchronous RAM. Each input word is a lookup, store,
// remove or read-slot request and yields exactly one output word. Lookup
// and remove walk the slots from slot 0, one RAM read per cycle, stopping at
// the first exact match; store stops at the first slot whose top byte is
// 0xFF and writes the key there (no duplicate check); read-slot does a
// single read. An unwritten or removed slot holds all ones, so lookup/remove
// of an all-ones key hit the lowest such slot. Time from accept to result
// is set by the one-read-per-cycle RAM walk: read-slot does one read, a full
// scan with no hit reads all NUM_SLOTS slots. One request is in flight at a
// time; the input is ready again once the previous result is loaded into
// the output register, even if that result is still waiting downstream.
// No clearing pass: per-slot valid flops make unwritten slots read as empty
// right after reset.
module credential_key_table_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ckt_pkg::ckt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ckt_pkg::ckt_out_t out_data_o
);
  import ckt_pkg::*;

  mem_req_t         mem_req;
  logic [KEY_W-1:0] rd_data;
  logic             res_valid;
  logic             res_take;
  ckt_out_t         res_data;

  logic             out_valid_q, out_valid_d;
  ckt_out_t         out_data_q, out_data_d;

  ckt_slot_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .rd_data_o (rd_data)
  );

  ckt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_ready_o  (in_ready_o),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .res_take_i  (res_take),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  // output register: free, or being drained this cycle
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import ckt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = NUM_SLOTS + 8;
  localparam int RAND_WORDS  = 220;  // per phase, four phases

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ckt_in_t  in_data;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ckt_out_t out_data;

  credential_key_table_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the key table, advanced once per accepted word.
  logic [KEY_W-1:0] key_table [NUM_SLOTS];
  // Keys recently stored, so random lookups and removes actually hit.
  logic [31:0]      stored_keys [$];
  // Results owed by the block, oldest first.
  ckt_out_t         owed_results [$];

  int errors;
  int cycle_cnt;
  int src_idle_pct;
  int dst_stall_pct;

  // Apply one request to the shadow table and return the word it yields.
  function automatic ckt_out_t table_apply(input ckt_in_t w);
    ckt_out_t         r;
    int               found;
    logic [KEY_W-1:0] k;
    r     = '0;
    found = -1;
    k     = w.card_key[KEY_W-1:0];
    case (w.req_type)
      REQ_LOOKUP, REQ_REMOVE: begin
        for (int i = 0; i < NUM_SLOTS; i++)
          if (found < 0 && key_table[i] == k) found = i;
        r.hit = (found >= 0);
        // removing the all-ones key rewrites an empty slot with all ones
        if (w.req_type == REQ_REMOVE && found >= 0) key_table[found] = '1;
      end
      REQ_STORE: begin
        // lowest slot with an 0xFF top byte; no duplicate check
        for (int i = 0; i < NUM_SLOTS; i++)
          if (found < 0 && key_table[i][KEY_W-1 -: 8] == EMPTY_BYTE) found = i;
        if (found >= 0) begin
          key_table[found] = k;
          r.hit = 1'b1;
          stored_keys.push_back(w.card_key);
          if (stored_keys.size() > 24) void'(stored_keys.pop_front());
        end
      end
      default: begin
        if (int'(w.slot_index) < NUM_SLOTS &&
            key_table[w.slot_index][KEY_W-1 -: 8] != EMPTY_BYTE) begin
          r.hit     = 1'b1;
          r.key_out = 32'(key_table[w.slot_index]);
        end
      end
    endcase
    return r;
  endfunction

  // Present one word, hold it until taken, then log what it must yield.
  // Called aligned to a rising edge; valid is only dropped when a gap is rolled.
  task automatic send_word(input ckt_in_t w, input bit typed, input ckt_out_t typed_res);
    ckt_out_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pred = table_apply(w);
    owed_results.push_back(typed ? typed_res : pred);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 5 && stored_keys.size() != 0)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    case (r)
      5:       return '1;
      6:       return {EMPTY_BYTE, 24'($urandom)};
      7:       return 32'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  // store_pct / remove_pct set the mix; the rest splits between lookup and read.
  function automatic ckt_in_t rand_word(input int store_pct, input int remove_pct);
    ckt_in_t w;
    int      r;
    r            = $urandom_range(99);
    w.card_key   = pick_key();
    w.slot_index = 4'($urandom);
    if (r < store_pct)                   w.req_type = REQ_STORE;
    else if (r < store_pct + remove_pct) w.req_type = REQ_REMOVE;
    else if (r[0])                       w.req_type = REQ_LOOKUP;
    else                                 w.req_type = REQ_READ;
    return w;
  endfunction

  // Directed rows. Expectation typed in only where obvious; otherwise predicted.
  typedef struct {
    req_e        req;
    logic [31:0] key;
    logic [3:0]  idx;
    bit          typed;
    logic        hit;
    logic [31:0] kout;
  } dir_row_t;

  localparam int N_DIR = 22;
  dir_row_t dir_rows [N_DIR] = '{
    '{REQ_READ,   32'h0000_0000, 4'd0,  1, 1'b0, 32'h0}, // empty after reset
    '{REQ_READ,   32'hFFFF_FFFF, 4'd15, 1, 1'b0, 32'h0}, // top slot, empty
    '{REQ_LOOKUP, 32'hFFFF_FFFF, 4'd0,  1, 1'b1, 32'h0}, // all-ones hits empty
    '{REQ_LOOKUP, 32'h0000_0000, 4'd0,  1, 1'b0, 32'h0},
    '{REQ_REMOVE, 32'h0000_0000, 4'd0,  1, 1'b0, 32'h0}, // nothing to remove
    '{REQ_REMOVE, 32'hFFFF_FFFF, 4'd0,  1, 1'b1, 32'h0}, // all-ones remove hits
    '{REQ_STORE,  32'h0000_0000, 4'd0,  1, 1'b1, 32'h0}, // slot 0
    '{REQ_STORE,  32'hFFFF_FFFF, 4'd0,  1, 1'b1, 32'h0}, // slot 1, stays empty
    '{REQ_STORE,  32'hFF12_3456, 4'd0,  1, 1'b1, 32'h0}, // overwrites slot 1
    '{REQ_LOOKUP, 32'hFF12_3456, 4'd0,  1, 1'b1, 32'h0},
    '{REQ_READ,   32'hFFFF_FFFF, 4'd1,  1, 1'b0, 32'h0}, // FF top byte reads empty
    '{REQ_READ,   32'hFFFF_FFFF, 4'd0,  1, 1'b1, 32'h0}, // occupied, key zero
    '{REQ_STORE,  32'h7FFF_FFFF, 4'd0,  0, 1'b0, 32'h0},
    '{REQ_STORE,  32'h8000_0000, 4'd0,  0, 1'b0, 32'h0},
    '{REQ_STORE,  32'h5A5A_A5A5, 4'd0,  0, 1'b0, 32'h0},
    '{REQ_READ,   32'h0000_0000, 4'd1,  0, 1'b0, 32'h0},
    '{REQ_LOOKUP, 32'h7FFF_FFFF, 4'd9,  0, 1'b0, 32'h0},
    '{REQ_REMOVE, 32'h8000_0000, 4'd0,  0, 1'b0, 32'h0},
    '{REQ_REMOVE, 32'h8000_0000, 4'd0,  0, 1'b0, 32'h0}, // second remove misses
    '{REQ_STORE,  32'h0000_0000, 4'd0,  0, 1'b0, 32'h0}, // duplicate allowed
    '{REQ_READ,   32'h0000_0000, 4'd2,  0, 1'b0, 32'h0},
    '{REQ_READ,   32'h0000_0000, 4'd3,  0, 1'b0, 32'h0}
  };

  // Idle mix per phase: none, sender only, receiver only, both.
  int phase_src  [4] = '{0, 62, 0, 28};
  int phase_dst  [4] = '{0, 0, 62, 28};
  // Op mix per phase: first fills the table past full, last drains it.
  int phase_stor [4] = '{60, 25, 35, 15};
  int phase_rmv  [4] = '{10, 30, 25, 55};

  // Result side: check each taken word against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected word hit %0b key_out %h", $time,
                   out_data.hit, out_data.key_out);
        end else begin
          ckt_out_t e;
          e = owed_results.pop_front();
          if (out_data.hit !== e.hit) begin
            errors++;
            $display("%0t: hit expected %0b actual %0b", $time, e.hit, out_data.hit);
          end
          if (out_data.key_out !== e.key_out) begin
            errors++;
            $display("%0t: key_out expected %h actual %h", $time,
                     e.key_out, out_data.key_out);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ckt_in_t w;
    ckt_out_t t;
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    for (int i = 0; i < NUM_SLOTS; i++) key_table[i] = '1;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corner cases
    foreach (dir_rows[i]) begin
      w.req_type   = dir_rows[i].req;
      w.card_key   = dir_rows[i].key;
      w.slot_index = dir_rows[i].idx;
      t.hit        = dir_rows[i].hit;
      t.key_out    = dir_rows[i].kout;
      send_word(w, dir_rows[i].typed, t);
    end

    // random phases
    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = phase_src[p];
      dst_stall_pct = phase_dst[p];
      for (int n = 0; n < RAND_WORDS; n++)
        send_word(rand_word(phase_stor[p], phase_rmv[p]), 1'b0, '0);
    end
    in_valid <= 1'b0;
    dst_stall_pct = 0;

    // drain, then give stray words a chance to show up
    while (owed_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ckt_pkg.sv
src/ckt_slot_mem.sv
src/ckt_ctrl.sv
src/credential_key_table_unit.sv
tb/tb_top.sv
